/* rtl/multi_segment_ramp_envelope_unit_defines.svh */
// assertion macros shared by the checker
`ifndef MULTI_SEGMENT_RAMP_ENVELOPE_UNIT_DEFINES_SVH
`define MULTI_SEGMENT_RAMP_ENVELOPE_UNIT_DEFINES_SVH

// implication checked on every rising edge outside reset
`define MSRE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs during reset
`define MSRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/msre_pkg.sv */
// ---------------------------------------------------------------------------
// msre_pkg
// shared widths, codes, reset constants and saturation helpers of the
// ramp envelope unit
// ---------------------------------------------------------------------------
package msre_pkg;

  localparam int MAX_SEGMENTS  = 8;
  localparam int SEG_BITS      = $clog2(MAX_SEGMENTS);
  localparam int COUNT_BITS    = 4;
  localparam int SAMPLE_BITS   = 16;
  localparam int LENGTH_BITS   = 24;
  localparam int LVL_BITS      = 24;
  localparam int LVL_FRAC      = 20;
  localparam int RATE_BITS     = 48;
  localparam int RATE_SHIFT    = 24;
  localparam int END_BITS      = 27;
  localparam int TIME_BITS     = END_BITS + 1;
  localparam int MUL_A_BITS    = RATE_BITS;
  localparam int MUL_B_BITS    = TIME_BITS;
  localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
  localparam int DIFF_BITS     = LVL_BITS + 1;
  localparam int DIVD_BITS     = DIFF_BITS + RATE_SHIFT;
  localparam int VSUM_BITS     = 53;
  localparam int IN_DATA_BITS  = 72;
  localparam int OUT_DATA_BITS = 72;
  localparam int CFG_IDX_BITS  = 1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_KEY_ON  = 2'd1,
    OP_KEY_OFF = 2'd2,
    OP_LOAD    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RAMP = 2'd1,
    PH_REL  = 2'd2
  } phase_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_SEGMENT_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_LEVEL   = 1'b1;

  localparam logic signed [LVL_BITS-1:0]  SEG0_TARGET = 24'sh100000;
  localparam logic [LENGTH_BITS-1:0]      SEG0_LENGTH = 24'd1000;
  localparam logic [END_BITS-1:0]         SEG0_END    = 27'd1000;
  localparam logic signed [RATE_BITS-1:0] SEG0_RATE   = 48'sd17592186044;
  localparam logic [LENGTH_BITS-1:0]      REL_LENGTH_RST = 24'd1000;
  localparam logic [END_BITS-1:0]         END_MAX     = {END_BITS{1'b1}};

  typedef logic signed [LVL_BITS-1:0]  level_t;
  typedef logic signed [RATE_BITS-1:0] rate_t;

  typedef struct packed {
    logic                  start;
    logic [MUL_A_BITS-1:0] a;
    logic [MUL_B_BITS-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                   start;
    logic [DIVD_BITS-1:0]   dividend;
    logic [LENGTH_BITS-1:0] divisor;
  } div_req_t;

  function automatic level_t sat_level(input logic signed [VSUM_BITS-1:0] v);
    logic signed [VSUM_BITS-1:0] hi;
    logic signed [VSUM_BITS-1:0] lo;
    hi = VSUM_BITS'(2 ** (LVL_BITS - 1) - 1);
    lo = -hi - VSUM_BITS'(1);
    if (v > hi) return level_t'(hi);
    else if (v < lo) return level_t'(lo);
    return level_t'(v);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [21:0] v);
    logic signed [21:0] hi;
    logic signed [21:0] lo;
    hi = 22'(2 ** (SAMPLE_BITS - 1) - 1);
    lo = -hi - 22'sd1;
    if (v > hi) return SAMPLE_BITS'(hi);
    else if (v < lo) return SAMPLE_BITS'(lo);
    return SAMPLE_BITS'(v);
  endfunction

endpackage

/* rtl/msre_mul.sv */
// ---------------------------------------------------------------------------
// msre_mul
// unsigned shift-add multiplier, one multiplier bit per cycle
// ---------------------------------------------------------------------------
module msre_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  msre_pkg::mul_req_t                 req,
  output logic                               done,
  output logic [msre_pkg::PROD_BITS-1:0]     prod
);
  import msre_pkg::*;

  localparam int CNT_BITS = $clog2(MUL_B_BITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(MUL_B_BITS - 1);

  logic [MUL_A_BITS-1:0] mcand;
  logic [CNT_BITS-1:0]   cnt;
  logic                  run;
  logic [MUL_A_BITS:0]   sum;

  assign sum = {1'b0, prod[PROD_BITS-1:MUL_B_BITS]} +
               (prod[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        prod  <= {{MUL_A_BITS{1'b0}}, req.b};
        mcand <= req.a;
        cnt   <= '0;
        run   <= 1'b1;
      end else if (run) begin
        prod <= {sum, prod[MUL_B_BITS-1:1]};
        cnt  <= cnt + 1'b1;
        if (cnt == LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/msre_div.sv */
// ---------------------------------------------------------------------------
// msre_div
// unsigned restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module msre_div (
  input  logic                           clk,
  input  logic                           rst,
  input  msre_pkg::div_req_t             req,
  output logic                           done,
  output logic [msre_pkg::DIVD_BITS-1:0] quo
);
  import msre_pkg::*;

  localparam int CNT_BITS = $clog2(DIVD_BITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(DIVD_BITS - 1);

  logic [LENGTH_BITS-1:0] dvsr;
  logic [LENGTH_BITS-1:0] rem;
  logic [CNT_BITS-1:0]    cnt;
  logic                   run;
  logic [LENGTH_BITS:0]   shifted;
  logic [LENGTH_BITS:0]   trial;
  logic                   ge;

  assign shifted = {rem, quo[DIVD_BITS-1]};
  assign ge      = shifted >= {1'b0, dvsr};
  assign trial   = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        dvsr <= req.divisor;
        rem  <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        rem <= ge ? trial[LENGTH_BITS-1:0] : shifted[LENGTH_BITS-1:0];
        quo <= {quo[DIVD_BITS-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/multi_segment_ramp_envelope_unit.sv */
// ---------------------------------------------------------------------------
// multi_segment_ramp_envelope_unit
// breakpoint ramp envelope that scales a sample stream
// ---------------------------------------------------------------------------
// usage: items arrive on s_t* with the operation in s_tuser; each item gives
// exactly one result on m_t*. the configuration channel writes the segment
// count (index 0) or the start level (index 1) between items.
// one item is in work at a time; s_tready is low until its result sits in
// the output register, which then waits for m_tready while the next item is
// already taken in.
// work per item: an idle tick skips the segment reads, a ramp tick makes two
// passes of the shared shift-add multiplier, a release tick one pass, and key
// on, key off and segment loads one pass of the shared restoring divider. a
// start level write keeps the block busy while segment 0's rate is redone.
// reset loads segment 0 with a unit ramp (target 1.0 over 1000 samples) and
// the release length 1000; other segments hold nothing meaningful until
// loaded.
// a stalled receiver holds the result in m_tdata; no result is lost.
// ---------------------------------------------------------------------------
module multi_segment_ramp_envelope_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // sample_in, seg_index, level_value, duration, use_level
  input  logic [msre_pkg::IN_DATA_BITS-1:0]     s_tdata,
  // op
  input  logic [1:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // sample_out, level, phase, segment, total_duration
  output logic [msre_pkg::OUT_DATA_BITS-1:0]    m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [msre_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [msre_pkg::LVL_BITS-1:0]         cfg_data
);
  import msre_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD0, S_RD1, S_MUL1, S_LVL, S_MUL2, S_DIV, S_DONE
  } state_t;

  state_t state;
  op_t    op;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [SEG_BITS-1:0]    idx;
  level_t                 lv;
  logic [LENGTH_BITS-1:0] dur;
  logic                   is_cfg;

  logic [COUNT_BITS-1:0]  count;
  level_t                 level;
  level_t                 base;
  phase_t                 phase;
  logic [SEG_BITS-1:0]    seg;
  logic [END_BITS-1:0]    elapsed;
  rate_t                  rel_rate;
  logic [LENGTH_BITS-1:0] rel_len;
  rate_t                  rel_acc;

  level_t                 tgt_mem  [MAX_SEGMENTS];
  logic [LENGTH_BITS-1:0] len_mem  [MAX_SEGMENTS];
  logic [END_BITS-1:0]    end_mem  [MAX_SEGMENTS];
  rate_t                  rate_mem [MAX_SEGMENTS];

  logic [SEG_BITS-1:0]    rd_addr;
  logic [SEG_BITS-1:0]    a0;
  logic [SEG_BITS-1:0]    a1;
  level_t                 h0_tgt;
  logic [END_BITS-1:0]    h0_end;
  level_t                 h1_tgt;
  rate_t                  h1_rate;
  logic [END_BITS-1:0]    h1_end;
  logic [LENGTH_BITS-1:0] h1_len;

  logic                   ramp_neg;
  logic                   div_neg;
  logic                   scale_neg;
  logic [END_BITS-1:0]    total;
  logic [SAMPLE_BITS-1:0] sample_o;
  logic                   o_valid;
  logic [OUT_DATA_BITS-1:0] o_data;

  mul_req_t               mul_req;
  logic                   mul_done;
  logic [PROD_BITS-1:0]   prod;
  div_req_t               div_req;
  logic                   div_done;
  logic [DIVD_BITS-1:0]   quo;

  // field unpack
  logic signed [SAMPLE_BITS-1:0] in_smp;
  logic [SEG_BITS-1:0]    in_idx;
  level_t                 in_lv;
  logic [LENGTH_BITS-1:0] in_dur;
  logic                   in_use;
  op_t                    in_op;

  assign in_smp = s_tdata[15:0];
  assign in_idx = s_tdata[18:16];
  assign in_lv  = s_tdata[42:19];
  assign in_dur = s_tdata[66:43];
  assign in_use = s_tdata[67];
  assign in_op  = op_t'(s_tuser);

  assign cfg_ready = (state == S_IDLE);
  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign m_tvalid  = o_valid;
  assign m_tdata   = o_data;

  logic [COUNT_BITS-1:0] cnt_eff;
  always_comb begin
    if (count == '0) cnt_eff = COUNT_BITS'(1);
    else if (count > COUNT_BITS'(MAX_SEGMENTS)) cnt_eff = COUNT_BITS'(MAX_SEGMENTS);
    else cnt_eff = count;
  end

  logic [SEG_BITS-1:0] last_seg;
  assign last_seg = SEG_BITS'(cnt_eff - 1'b1);
  assign rd_addr  = (state == S_RD0) ? a0 : a1;

  // ramp operands
  logic signed [TIME_BITS-1:0] t_val;
  logic [TIME_BITS-1:0]        t_mag;
  logic [RATE_BITS-1:0]        r_mag;
  logic                        r_neg;
  rate_t                       cur_rate;
  assign cur_rate = rate_mem[rd_addr];
  assign t_val = $signed({1'b0, elapsed}) -
                 ((seg != '0) ? $signed({1'b0, h0_end}) : $signed(TIME_BITS'(0)));
  assign t_mag = t_val[TIME_BITS-1] ? TIME_BITS'(-t_val) : TIME_BITS'(t_val);
  assign r_neg = cur_rate[RATE_BITS-1];
  assign r_mag = r_neg ? RATE_BITS'(-cur_rate) : RATE_BITS'(cur_rate);

  // level after the ramp multiply
  logic [VSUM_BITS-1:0]        m_zx;
  logic signed [VSUM_BITS-1:0] v_start;
  logic signed [VSUM_BITS-1:0] v_sum;
  logic signed [VSUM_BITS-1:0] v_tgt;
  logic signed [VSUM_BITS-1:0] v_clip;
  level_t                      ramp_lvl;
  assign m_zx    = VSUM_BITS'(prod[PROD_BITS-2:RATE_SHIFT]);
  assign v_start = (seg == '0) ? VSUM_BITS'(base) : VSUM_BITS'(h0_tgt);
  assign v_sum   = ramp_neg ? v_start - $signed(m_zx) : v_start + $signed(m_zx);
  assign v_tgt   = VSUM_BITS'(h1_tgt);
  always_comb begin
    v_clip = v_sum;
    if (!h1_rate[RATE_BITS-1] && v_sum > v_tgt) v_clip = v_tgt;
    if (h1_rate[RATE_BITS-1] && v_sum < v_tgt) v_clip = v_tgt;
  end
  assign ramp_lvl = sat_level(v_clip);

  logic [END_BITS-1:0] elapsed_inc;
  assign elapsed_inc = (elapsed == END_MAX) ? elapsed : elapsed + 1'b1;

  // release step
  logic signed [RATE_BITS:0]   rel_sum;
  logic signed [RATE_BITS:0]   rel_goal;
  rate_t                       rel_new;
  level_t                      rel_lvl;
  assign rel_goal = (RATE_BITS+1)'(base) <<< RATE_SHIFT;
  assign rel_sum  = (RATE_BITS+1)'(rel_acc) + (RATE_BITS+1)'(rel_rate);
  always_comb begin
    rel_new = RATE_BITS'(rel_sum);
    if (rel_rate > 0 && rel_sum > rel_goal) rel_new = RATE_BITS'(rel_goal);
    if (rel_rate < 0 && rel_sum < rel_goal) rel_new = RATE_BITS'(rel_goal);
  end
  assign rel_lvl = rel_new[RATE_BITS-1:RATE_SHIFT];

  // scale multiply operands
  level_t                  scale_lvl;
  logic [LVL_BITS-1:0]     lvl_mag;
  logic [SAMPLE_BITS:0]    smp_mag;
  logic signed [SAMPLE_BITS:0] smp_x;
  assign scale_lvl = (state == S_LVL) ? ramp_lvl : rel_lvl;
  assign lvl_mag   = scale_lvl[LVL_BITS-1] ? LVL_BITS'(-scale_lvl) : LVL_BITS'(scale_lvl);
  assign smp_x     = (SAMPLE_BITS+1)'(smp);
  assign smp_mag   = smp_x[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-smp_x) : (SAMPLE_BITS+1)'(smp_x);

  // scaled result
  logic signed [41:0] p_signed;
  logic [SAMPLE_BITS-1:0] scaled;
  assign p_signed = scale_neg ? -$signed({1'b0, prod[40:0]}) : $signed({1'b0, prod[40:0]});
  assign scaled   = sat_sample(p_signed[41:LVL_FRAC]);

  logic [SAMPLE_BITS-1:0] idle_value;
  assign idle_value = sat_sample(22'(base >>> (LVL_FRAC - (SAMPLE_BITS - 1))));

  // rate division operands
  logic signed [DIFF_BITS-1:0] diff;
  logic [DIFF_BITS-1:0]        diff_mag;
  logic [LENGTH_BITS-1:0]      divisor;
  logic [LENGTH_BITS-1:0]      load_len;
  logic [END_BITS:0]           load_end;
  assign load_len = (dur == '0) ? LENGTH_BITS'(1) : dur;
  assign load_end = ((idx == '0) ? '0 : {1'b0, h0_end}) + (END_BITS+1)'(load_len);
  always_comb begin
    if (is_cfg) begin
      diff    = DIFF_BITS'(tgt_mem[a1]) - DIFF_BITS'(base);
      divisor = len_mem[a1];
    end else begin
      unique case (op)
        OP_KEY_ON: begin
          diff    = DIFF_BITS'(tgt_mem[a1]) - DIFF_BITS'(level);
          divisor = len_mem[a1];
        end
        OP_KEY_OFF: begin
          diff    = DIFF_BITS'(base) - DIFF_BITS'(level);
          divisor = rel_len;
        end
        OP_LOAD: begin
          diff    = DIFF_BITS'(lv) - ((idx == '0) ? DIFF_BITS'(base) : DIFF_BITS'(h0_tgt));
          divisor = load_len;
        end
        default: begin
          diff    = '0;
          divisor = load_len;
        end
      endcase
    end
  end
  assign diff_mag = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);

  logic div_start;
  assign div_start = (state == S_RD1) && (is_cfg || op != OP_TICK);
  assign div_req.start    = div_start;
  assign div_req.dividend = {diff_mag, {RATE_SHIFT{1'b0}}};
  assign div_req.divisor  = (divisor == '0) ? LENGTH_BITS'(1) : divisor;

  // saturated signed rate from the quotient
  localparam logic [DIVD_BITS-1:0] Q_POS_MAX = DIVD_BITS'(2 ** (RATE_BITS - 1) - 1);
  rate_t new_rate;
  logic [DIVD_BITS-1:0] quo_neg;
  assign quo_neg = -quo;
  always_comb begin
    if (!div_neg) new_rate = (quo > Q_POS_MAX) ? RATE_BITS'(Q_POS_MAX) : RATE_BITS'(quo);
    else if (quo > Q_POS_MAX + 1'b1) new_rate = rate_t'({1'b1, {(RATE_BITS-1){1'b0}}});
    else new_rate = quo_neg[RATE_BITS-1:0];
  end

  logic mul_ramp_start;
  logic mul_scale_start;
  assign mul_ramp_start  = (state == S_RD1) && !is_cfg && op == OP_TICK && phase == PH_RAMP;
  assign mul_scale_start = (state == S_LVL) ||
                           ((state == S_RD1) && !is_cfg && op == OP_TICK && phase == PH_REL);
  always_comb begin
    mul_req.start = mul_ramp_start || mul_scale_start;
    if (mul_ramp_start) begin
      mul_req.a = r_mag;
      mul_req.b = t_mag;
    end else begin
      mul_req.a = MUL_A_BITS'(lvl_mag);
      mul_req.b = MUL_B_BITS'(smp_mag);
    end
  end

  msre_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .done(mul_done), .prod(prod));
  msre_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quo(quo));

  // segment store, entry 0 has a defined reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_mem[0]  <= SEG0_TARGET;
      len_mem[0]  <= SEG0_LENGTH;
      end_mem[0]  <= SEG0_END;
      rate_mem[0] <= SEG0_RATE;
    end else begin
      if (state == S_RD1 && !is_cfg && op == OP_LOAD) begin
        tgt_mem[idx] <= lv;
        len_mem[idx] <= load_len;
        end_mem[idx] <= load_end[END_BITS] ? END_MAX : load_end[END_BITS-1:0];
      end
      if (state == S_DIV && div_done && (is_cfg || op != OP_KEY_OFF)) begin
        rate_mem[(is_cfg || op == OP_KEY_ON) ? SEG_BITS'(0) : idx] <= new_rate;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= COUNT_BITS'(1);
      level    <= '0;
      base     <= '0;
      phase    <= PH_IDLE;
      seg      <= '0;
      elapsed  <= END_BITS'(1);
      rel_rate <= '0;
      rel_len  <= REL_LENGTH_RST;
      rel_acc  <= '0;
      is_cfg   <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (m_tready) o_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_SEGMENT_COUNT) begin
              count <= cfg_data[COUNT_BITS-1:0];
            end else begin
              level  <= level_t'(cfg_data);
              base   <= level_t'(cfg_data);
              is_cfg <= 1'b1;
              a0     <= '0;
              a1     <= '0;
              state  <= S_RD0;
            end
          end else if (s_tvalid) begin
            op       <= in_op;
            smp      <= in_smp;
            idx      <= in_idx;
            lv       <= in_lv;
            dur      <= in_dur;
            is_cfg   <= 1'b0;
            sample_o <= '0;
            total    <= '0;
            state    <= S_RD0;
            unique case (in_op)
              OP_TICK: begin
                a0 <= seg - 1'b1;
                a1 <= seg;
                if (phase == PH_IDLE) begin
                  sample_o <= idle_value;
                  state    <= S_DONE;
                end
              end
              OP_KEY_ON: begin
                if (in_use) level <= in_lv;
                base    <= in_use ? in_lv : level;
                elapsed <= END_BITS'(1);
                phase   <= PH_RAMP;
                seg     <= '0;
                a0      <= last_seg;
                a1      <= '0;
              end
              OP_KEY_OFF: begin
                if (in_use) base <= in_lv;
                if (in_dur != '0) rel_len <= in_dur;
                elapsed <= END_BITS'(1);
                phase   <= PH_REL;
                rel_acc <= RATE_BITS'(level) <<< RATE_SHIFT;
                a0      <= '0;
                a1      <= '0;
              end
              OP_LOAD: begin
                a0 <= in_idx - 1'b1;
                a1 <= in_idx;
              end
            endcase
          end
        end
        S_RD0: begin
          h0_tgt <= tgt_mem[rd_addr];
          h0_end <= end_mem[rd_addr];
          state  <= S_RD1;
        end
        S_RD1: begin
          h1_tgt  <= tgt_mem[rd_addr];
          h1_rate <= cur_rate;
          h1_end  <= end_mem[rd_addr];
          h1_len  <= len_mem[rd_addr];
          div_neg <= diff[DIFF_BITS-1];
          if (div_start) begin
            state <= S_DIV;
            if (!is_cfg && op == OP_KEY_ON) total <= h0_end;
            if (!is_cfg && op == OP_KEY_OFF) total <= END_BITS'(rel_len);
          end else if (phase == PH_RAMP) begin
            ramp_neg <= r_neg ^ t_val[TIME_BITS-1];
            state    <= S_MUL1;
          end else begin
            rel_acc   <= rel_new;
            level     <= rel_lvl;
            elapsed   <= elapsed_inc;
            scale_neg <= rel_lvl[LVL_BITS-1] ^ smp[SAMPLE_BITS-1];
            state     <= S_MUL2;
          end
        end
        S_MUL1: begin
          if (mul_done) state <= S_LVL;
        end
        S_LVL: begin
          level     <= ramp_lvl;
          elapsed   <= elapsed_inc;
          scale_neg <= ramp_lvl[LVL_BITS-1] ^ smp[SAMPLE_BITS-1];
          if ((COUNT_BITS'(seg) + 1'b1) < cnt_eff && elapsed_inc >= h1_end) seg <= seg + 1'b1;
          state <= S_MUL2;
        end
        S_MUL2: begin
          if (mul_done) begin
            sample_o <= scaled;
            state    <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!is_cfg && op == OP_KEY_OFF) rel_rate <= new_rate;
            state <= is_cfg ? S_IDLE : S_DONE;
          end
        end
        S_DONE: begin
          if (!o_valid || m_tready) begin
            o_valid <= 1'b1;
            o_data  <= {total, seg, phase, level, sample_o};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/msre_checker.sv */
// ---------------------------------------------------------------------------
// msre_checker
// port-level checks of the ramp envelope unit, bound to the top level
// ---------------------------------------------------------------------------
`include "multi_segment_ramp_envelope_unit_defines.svh"

module msre_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [msre_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);
  import msre_pkg::*;

  // a result waiting on the receiver stays offered
  `MSRE_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
  // one item at a time: no second transfer straight after an accepted one
  `MSRE_ASSERT(a_one_item, clk, rst, s_tvalid && s_tready |=> !s_tready, "item overlap")
  // a configuration write and an item never share an edge
  `MSRE_ASSERT(a_cfg_excl, clk, rst, !(cfg_valid && cfg_ready && s_tvalid && s_tready),
               "config and item together")
  // the phase field never carries the unused code
  `MSRE_ASSERT(a_phase, clk, rst, m_tvalid |-> m_tdata[41:40] != 2'd3, "bad phase")
  // nothing is offered straight out of reset
  `MSRE_ASSERT_ALWAYS(a_rst_out, clk, $past(rst) |-> !m_tvalid, "result after reset")

endmodule

bind multi_segment_ramp_envelope_unit msre_checker u_msre_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the breakpoint ramp envelope unit: a directed table
// then bursty random envelopes, each result checked against a local model or,
// for some table rows, against a fixed expected result
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import msre_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam longint EMAX = (64'sd1 <<< END_BITS) - 1;

  typedef struct {
    op_t op;
    logic signed [15:0] smp;
    logic [2:0] idx;
    logic signed [23:0] lv;
    logic [23:0] dur;
    logic use_lv;
  } env_item_t;

  typedef struct {
    logic signed [15:0] smp_out;
    logic signed [23:0] lvl;
    phase_t ph;
    logic [2:0] seg;
    logic [26:0] total;
  } env_result_t;

  typedef struct {
    env_item_t it;
    bit typed;
    env_result_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [LVL_BITS-1:0] cfg_data = '0;

  multi_segment_ramp_envelope_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // envelope model state
  int unsigned seg_count;
  longint lvl_q, base_q, elapsed_q, rel_rate_q, rel_len_q, rel_acc_q;
  phase_t phase_q;
  int unsigned act_seg;
  longint seg_tgt[MAX_SEGMENTS];
  longint seg_len[MAX_SEGMENTS];
  longint seg_end[MAX_SEGMENTS];
  longint seg_rate[MAX_SEGMENTS];

  env_result_t pending_results[$];
  table_row_t dir_rows[$];
  int fails = 0;
  int cycles = 0;
  int burst_left = 0;
  bit steady_rx = 1'b0;
  int stall_left = 0;

  function automatic longint sat_to(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint floor_div(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) + ((64'sd1 <<< s) - 1)) >>> s);
  endfunction

  function automatic longint ramp_rate(longint diff, longint len);
    if (len == 0) len = 1;
    return sat_to((diff * (64'sd1 <<< RATE_SHIFT)) / len, RATE_BITS);
  endfunction

  // rate * t / 2^24 truncated toward zero, split to stay within 64 bits
  function automatic longint ramp_delta(longint rate, longint t);
    longint mr, mt, m;
    bit neg;
    neg = (rate < 0) != (t < 0);
    mr = rate < 0 ? -rate : rate;
    mt = t < 0 ? -t : t;
    m = (mr >>> RATE_SHIFT) * mt + (((mr & ((64'sd1 <<< RATE_SHIFT) - 1)) * mt) >>> RATE_SHIFT);
    return neg ? -m : m;
  endfunction

  function automatic logic signed [15:0] scaled(longint x, longint l);
    return 16'(sat_to(floor_div(x * l, LVL_FRAC), SAMPLE_BITS));
  endfunction

  function automatic void envelope_reset();
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      seg_tgt[k] = 0; seg_len[k] = 0; seg_end[k] = 0; seg_rate[k] = 0;
    end
    seg_count = 1; lvl_q = 0; base_q = 0; phase_q = PH_IDLE; act_seg = 0;
    elapsed_q = 1; rel_rate_q = 0; rel_len_q = 1000; rel_acc_q = 0;
    seg_tgt[0] = 64'sd1 <<< LVL_FRAC; seg_len[0] = 1000; seg_end[0] = 1000;
    seg_rate[0] = ramp_rate(seg_tgt[0], 1000);
  endfunction

  function automatic void envelope_config(logic [CFG_IDX_BITS-1:0] idx, logic [23:0] val);
    if (idx == REG_SEGMENT_COUNT) begin
      seg_count = val[3:0];
    end else begin
      lvl_q = longint'($signed(val));
      base_q = lvl_q;
      seg_rate[0] = ramp_rate(seg_tgt[0] - base_q, seg_len[0]);
    end
  endfunction

  function automatic int unsigned count_eff();
    if (seg_count == 0) return 1;
    if (seg_count > MAX_SEGMENTS) return MAX_SEGMENTS;
    return seg_count;
  endfunction

  function automatic env_result_t envelope_step(env_item_t it);
    env_result_t r;
    longint v, t, goal, lv, prev, pend, e, len;
    int unsigned i;
    r.smp_out = '0;
    r.total = '0;
    lv = longint'(it.lv);
    case (it.op)
      OP_TICK: begin
        if (phase_q == PH_IDLE) begin
          r.smp_out = scaled(64'sd1 <<< (SAMPLE_BITS - 1), base_q);
        end else if (phase_q == PH_REL) begin
          goal = base_q * (64'sd1 <<< RATE_SHIFT);
          rel_acc_q += rel_rate_q;
          if (rel_rate_q > 0 && rel_acc_q > goal) rel_acc_q = goal;
          if (rel_rate_q < 0 && rel_acc_q < goal) rel_acc_q = goal;
          lvl_q = sat_to(floor_div(rel_acc_q, RATE_SHIFT), LVL_BITS);
          if (elapsed_q < EMAX) elapsed_q++;
          r.smp_out = scaled(longint'(it.smp), lvl_q);
        end else begin
          i = act_seg;
          t = elapsed_q;
          v = base_q;
          if (i > 0) begin
            t -= seg_end[i-1];
            v = seg_tgt[i-1];
          end
          v += ramp_delta(seg_rate[i], t);
          if (seg_rate[i] >= 0 && v > seg_tgt[i]) v = seg_tgt[i];
          if (seg_rate[i] < 0 && v < seg_tgt[i]) v = seg_tgt[i];
          lvl_q = sat_to(v, LVL_BITS);
          if (elapsed_q < EMAX) elapsed_q++;
          if (i + 1 < count_eff() && elapsed_q >= seg_end[i]) act_seg = i + 1;
          r.smp_out = scaled(longint'(it.smp), lvl_q);
        end
      end
      OP_KEY_ON: begin
        if (it.use_lv) lvl_q = lv;
        base_q = lvl_q;
        elapsed_q = 1;
        phase_q = PH_RAMP;
        act_seg = 0;
        seg_rate[0] = ramp_rate(seg_tgt[0] - lvl_q, seg_len[0]);
        r.total = 27'(seg_end[count_eff() - 1]);
      end
      OP_KEY_OFF: begin
        if (it.use_lv) base_q = lv;
        if (it.dur != 0) rel_len_q = longint'(it.dur);
        elapsed_q = 1;
        phase_q = PH_REL;
        rel_rate_q = ramp_rate(base_q - lvl_q, rel_len_q);
        rel_acc_q = lvl_q * (64'sd1 <<< RATE_SHIFT);
        r.total = 27'(rel_len_q);
      end
      default: begin
        len = it.dur == 0 ? 1 : longint'(it.dur);
        prev = it.idx == 0 ? base_q : seg_tgt[it.idx-1];
        pend = it.idx == 0 ? 0 : seg_end[it.idx-1];
        e = pend + len;
        seg_tgt[it.idx] = lv;
        seg_len[it.idx] = len;
        seg_end[it.idx] = e > EMAX ? EMAX : e;
        seg_rate[it.idx] = ramp_rate(lv - prev, len);
      end
    endcase
    r.lvl = 24'(lvl_q);
    r.ph = phase_q;
    r.seg = 3'(act_seg);
    return r;
  endfunction

  // sends one item at a negedge, returns at a negedge after the transfer
  task automatic send_item(input env_item_t it, input bit typed, input env_result_t tr);
    env_result_t r;
    int gap;
    s_tuser = it.op;
    s_tdata = {4'b0, it.use_lv, it.dur, it.lv, it.idx, it.smp};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = envelope_step(it);
    pending_results.push_back(typed ? tr : r);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid = 1'b0;
      gap = $urandom_range(0, 12);
      burst_left = $urandom_range(0, 10);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [23:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    envelope_config(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain_results();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic add_row(input op_t op, input logic [15:0] smp, input logic [2:0] idx,
                         input logic [23:0] lv, input logic [23:0] dur, input logic use_lv,
                         input bit typed, input env_result_t r);
    table_row_t row;
    row.it.op = op; row.it.smp = smp; row.it.idx = idx; row.it.lv = lv;
    row.it.dur = dur; row.it.use_lv = use_lv; row.typed = typed; row.res = r;
    dir_rows.push_back(row);
  endtask

  function automatic env_item_t random_item();
    env_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.op = sel < 75 ? OP_TICK : (sel < 84 ? OP_KEY_ON : (sel < 92 ? OP_KEY_OFF : OP_LOAD));
    it.smp = 16'($urandom);
    it.idx = 3'($urandom_range(0, 7));
    it.lv = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($signed($urandom_range(0, 8)) - 4) <<< 18;
    it.use_lv = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0: it.dur = 24'($urandom);
      1: it.dur = '0;
      default: it.dur = 24'($urandom_range(1, 12));
    endcase
    return it;
  endfunction

  // receiver: random stalls, with stall-free stretches
  always @(negedge clk) begin
    if (cycles % 700 == 0) steady_rx <= ($urandom_range(0, 2) == 0);
    if (steady_rx) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 20);
    end
  end

  always @(posedge clk) begin
    env_result_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fails++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[15:0] !== exp_r.smp_out) begin
          $error("sample_out expected %0d got %0d", exp_r.smp_out, $signed(m_tdata[15:0]));
          fails++;
        end
        if (m_tdata[39:16] !== exp_r.lvl) begin
          $error("level expected %0d got %0d", exp_r.lvl, $signed(m_tdata[39:16]));
          fails++;
        end
        if (m_tdata[41:40] !== exp_r.ph) begin
          $error("phase expected %0d got %0d", exp_r.ph, m_tdata[41:40]);
          fails++;
        end
        if (m_tdata[44:42] !== exp_r.seg) begin
          $error("segment expected %0d got %0d", exp_r.seg, m_tdata[44:42]);
          fails++;
        end
        if (m_tdata[71:45] !== exp_r.total) begin
          $error("total_duration expected %0d got %0d", exp_r.total, m_tdata[71:45]);
          fails++;
        end
      end
    end
  end

  initial begin
    env_result_t none, r_idle, r_on, r_off;
    int cnt_set[4] = '{8, 3, 8, 5};
    logic [23:0] lvl_set[4];
    none = '{default: '0, ph: PH_IDLE};
    r_idle = '{smp_out: 16'sd0, lvl: 24'sd0, ph: PH_IDLE, seg: 3'd0, total: 27'd0};
    r_on = '{smp_out: 16'sd0, lvl: 24'sd0, ph: PH_RAMP, seg: 3'd0, total: 27'd1000};
    r_off = '{smp_out: 16'sd0, lvl: 24'sd0, ph: PH_REL, seg: 3'd0, total: 27'd1000};
    lvl_set[0] = 24'h800000;
    lvl_set[1] = 24'h7fffff;
    lvl_set[2] = 24'h000000;
    lvl_set[3] = 24'($urandom);
    envelope_reset();

    // directed table: reset state, sample extremes, key on/off, all eight loads
    add_row(OP_TICK, 16'h7fff, 0, 0, 0, 0, 1, r_idle);
    add_row(OP_KEY_ON, 16'h0000, 0, 0, 0, 0, 1, r_on);
    add_row(OP_KEY_OFF, 16'h0000, 0, 0, 0, 0, 1, r_off);
    add_row(OP_KEY_ON, 16'h0000, 0, 0, 0, 0, 1, r_on);
    add_row(OP_TICK, 16'h7fff, 0, 0, 0, 0, 0, none);
    add_row(OP_TICK, 16'h8000, 0, 0, 0, 0, 0, none);
    add_row(OP_KEY_OFF, 16'h0000, 0, 24'h7fffff, 24'hffffff, 1, 0, none);
    add_row(OP_TICK, 16'h7fff, 0, 0, 0, 0, 0, none);
    add_row(OP_KEY_OFF, 16'h0000, 0, 24'h800000, 24'd2, 1, 0, none);
    add_row(OP_TICK, 16'hffff, 0, 0, 0, 0, 0, none);
    add_row(OP_TICK, 16'h8000, 0, 0, 0, 0, 0, none);
    add_row(OP_LOAD, 16'h0000, 0, 24'h7fffff, 24'd0, 0, 0, none);
    add_row(OP_LOAD, 16'h0000, 1, 24'h800000, 24'd1, 0, 0, none);
    add_row(OP_LOAD, 16'h0000, 2, 24'h100000, 24'd3, 0, 0, none);
    add_row(OP_LOAD, 16'h0000, 3, 24'hf00000, 24'd2, 0, 0, none);
    add_row(OP_LOAD, 16'h0000, 4, 24'h040000, 24'd4, 0, 0, none);
    add_row(OP_LOAD, 16'h0000, 5, 24'h7fffff, 24'd1, 0, 0, none);
    add_row(OP_LOAD, 16'h0000, 6, 24'h000000, 24'd2, 0, 0, none);
    add_row(OP_LOAD, 16'h0000, 7, 24'h080000, 24'hffffff, 0, 0, none);
    add_row(OP_KEY_ON, 16'h0000, 0, 24'h800000, 0, 1, 0, none);
    add_row(OP_TICK, 16'h7fff, 0, 0, 0, 0, 0, none);
    add_row(OP_TICK, 16'h8000, 0, 0, 0, 0, 0, none);
    add_row(OP_TICK, 16'h0000, 0, 0, 0, 0, 0, none);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);
    drain_results();

    // random phases, each under its own count and start level
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_SEGMENT_COUNT, 24'(cnt_set[p]));
      write_reg(REG_START_LEVEL, lvl_set[p]);
      if (p == 3) write_reg(REG_SEGMENT_COUNT, 24'd1);
      for (int n = 0; n < 125; n++) send_item(random_item(), 0, none);
      drain_results();
    end

    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/msre_pkg.sv
rtl/msre_mul.sv
rtl/msre_div.sv
rtl/multi_segment_ramp_envelope_unit.sv
rtl/msre_checker.sv
sim/tb_top.sv
